// ----- design/isepq_pkg.sv -----
package isepq_pkg;

    localparam int MODE_W = 3;

    typedef enum logic [2:0] {
        MODE_SUBMIT     = 3'd0,
        MODE_TAKE       = 3'd1,
        MODE_ATTACH     = 3'd2,
        MODE_NEUTRALIZE = 3'd3,
        MODE_DETACH     = 3'd4,
        MODE_RECONNECT  = 3'd5
    } mode_t;

    localparam logic [1:0] KIND_STATE   = 2'd0;
    localparam logic [1:0] KIND_NEUTRAL = 2'd1;
    localparam logic [1:0] KIND_ATTACH  = 2'd2;
    localparam logic [1:0] KIND_DETACH  = 2'd3;

    localparam logic [1:0] CFG_CONTROL_LIMIT = 2'd0;
    localparam logic [1:0] CFG_EDGE_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_EDGE_LIFETIME = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] now;
        logic [15:0] pad_buttons;
        logic [31:0] trigger_word;
        logic [63:0] stick_word;
    } in_req_t;

    typedef struct packed {
        logic        accepted;
        logic        item_valid;
        logic [1:0]  item_kind;
        logic [15:0] out_buttons;
        logic [31:0] out_triggers;
        logic [63:0] out_sticks;
        logic [31:0] drop_total;
        logic [4:0]  edges_waiting;
    } out_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PURGE,
        ST_EXEC,
        ST_SHIFT,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the request
        logic purge_pop;  // drop the head edge during the purge
        logic exec;       // carry out the request's main action
        logic shift;      // one step of a pending edge shift
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_purge;  // request is submit, or take with empty control FIFO
        logic head_expired; // edge FIFO non-empty and head expired
        logic shift_busy;   // edge shift still in progress
    } status_t;

endpackage

// ----- design/isepq_ctrl.sv -----
module isepq_ctrl
    import isepq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PURGE;
                end
            end
            ST_PURGE:
            begin
                // When needed, expired head edges are removed one step at a time.
                if (status.shift_busy)
                begin
                    cmd.shift = 1'b1;
                end
                else if (status.needs_purge && status.head_expired)
                begin
                    cmd.purge_pop = 1'b1;
                end
                else
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (status.shift_busy)
                begin
                    cmd.shift = 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/isepq_dp.sv -----
module isepq_dp
    import isepq_pkg::*;
#(
    parameter int CTRL_DEPTH = 4,
    parameter int EDGE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  in_req_t     in_req,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  cmd_t        cmd,
    output status_t     status,
    output out_req_t    out_req
);

    localparam int CW  = (CTRL_DEPTH > 1) ? $clog2(CTRL_DEPTH) : 1;
    localparam int CFW = $clog2(CTRL_DEPTH + 1);
    localparam int EW  = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
    localparam int EFW = $clog2(EDGE_DEPTH + 1);
    localparam logic [CFW-1:0] CTRL_FULL = CFW'(CTRL_DEPTH);
    localparam logic [EFW-1:0] EDGE_FULL = EFW'(EDGE_DEPTH);

    // Configuration registers.
    logic [2:0]  control_limit_reg;
    logic [4:0]  edge_limit_reg;
    logic [31:0] edge_lifetime_reg;

    // Control FIFO as a circular buffer (small register array).
    logic [1:0]  ck_mem [CTRL_DEPTH];
    logic [15:0] cb_mem [CTRL_DEPTH];
    logic [31:0] ct_mem [CTRL_DEPTH];
    logic [63:0] cs_mem [CTRL_DEPTH];
    logic [63:0] cv_mem [CTRL_DEPTH];
    logic [CW-1:0]  chead_reg;
    logic [CFW-1:0] cfill_reg;

    // Edge FIFO: memory with head and fill.
    logic [15:0] eb_mem [EDGE_DEPTH];
    logic [31:0] et_mem [EDGE_DEPTH];
    logic [63:0] es_mem [EDGE_DEPTH];
    logic [63:0] ev_mem [EDGE_DEPTH];
    logic [31:0] etm_mem [EDGE_DEPTH];
    logic [EW-1:0]  ehead_reg;
    logic [EFW-1:0] efill_reg;

    logic        lp_reg;
    logic [1:0]  lk_reg;
    logic [15:0] lb_reg;
    logic [31:0] lt_reg;
    logic [63:0] ls_reg;
    logic [63:0] lv_reg;
    logic [63:0] vc_reg;
    logic [63:0] em_reg;
    logic [31:0] drop_reg;

    in_req_t  req_reg;
    out_req_t res_reg;
    out_req_t exec_res;

    // Head edge time is kept in a register, refreshed after every head change.
    logic [31:0] htime_reg;
    logic        hrefresh_reg;
    logic        hrefresh_next;

    logic [CFW-1:0] ccap;
    logic [EFW-1:0] ecap;
    logic [EW-1:0]  etail;
    logic [31:0]    age;
    logic [63:0]    ctrl_ver_head;
    logic [63:0]    edge_ver_head;

    function automatic logic [CW-1:0] cinc(input logic [CW-1:0] p, input logic [CFW-1:0] n);
        logic [CFW:0] s;
        s = {1'b0, CFW'(p)} + {1'b0, n};
        if (s >= (CFW+1)'(CTRL_DEPTH))
        begin
            s = s - (CFW+1)'(CTRL_DEPTH);
        end
        return s[CW-1:0];
    endfunction

    function automatic logic [EW-1:0] einc(input logic [EW-1:0] p, input logic [EFW-1:0] n);
        logic [EFW:0] s;
        s = {1'b0, EFW'(p)} + {1'b0, n};
        if (s >= (EFW+1)'(EDGE_DEPTH))
        begin
            s = s - (EFW+1)'(EDGE_DEPTH);
        end
        return s[EW-1:0];
    endfunction

    always_comb
    begin
        if ({1'b0, control_limit_reg} < 4'(CTRL_DEPTH) || CTRL_DEPTH > 7)
        begin
            ccap = CFW'(control_limit_reg);
        end
        else
        begin
            ccap = CTRL_FULL;
        end
        if ({1'b0, edge_limit_reg} < 6'(EDGE_DEPTH) || EDGE_DEPTH > 31)
        begin
            ecap = EFW'(edge_limit_reg);
        end
        else
        begin
            ecap = EDGE_FULL;
        end
    end

    assign etail         = einc(ehead_reg, efill_reg);
    assign age           = req_reg.now - htime_reg;
    assign ctrl_ver_head = cv_mem[chead_reg];
    assign edge_ver_head = ev_mem[ehead_reg];

    assign status.needs_purge = (req_reg.mode == MODE_SUBMIT) ||
                                (req_reg.mode == MODE_TAKE && cfill_reg == '0);
    assign status.head_expired = (efill_reg != '0) && (age >= edge_lifetime_reg);
    assign status.shift_busy   = hrefresh_reg;

    assign out_req = res_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_req;
        end
        if (hrefresh_reg)
        begin
            htime_reg <= etm_mem[ehead_reg];
        end
    end

    // The head stamp must be reloaded whenever the edge FIFO's head moves or
    // its first entry is written.
    always_comb
    begin
        hrefresh_next = cmd.purge_pop;
        if (cmd.exec)
        begin
            case (req_reg.mode)
                MODE_SUBMIT:
                begin
                    if (lp_reg && lb_reg != req_reg.pad_buttons && ecap != '0 &&
                        (efill_reg >= ecap || efill_reg == '0))
                    begin
                        hrefresh_next = 1'b1;
                    end
                end
                MODE_TAKE:
                begin
                    if (cfill_reg == '0 && efill_reg != '0)
                    begin
                        hrefresh_next = 1'b1;
                    end
                end
                default:
                begin
                    hrefresh_next = cmd.purge_pop;
                end
            endcase
        end
    end

    // Result of the request, taken from the state before it is updated.
    always_comb
    begin
        exec_res = '0;
        exec_res.accepted = 1'b1;
        case (req_reg.mode)
            MODE_TAKE:
            begin
                if (cfill_reg != '0)
                begin
                    exec_res.item_valid   = 1'b1;
                    exec_res.item_kind    = ck_mem[chead_reg];
                    exec_res.out_buttons  = cb_mem[chead_reg];
                    exec_res.out_triggers = ct_mem[chead_reg];
                    exec_res.out_sticks   = cs_mem[chead_reg];
                end
                else if (efill_reg != '0)
                begin
                    exec_res.item_valid   = 1'b1;
                    exec_res.item_kind    = KIND_STATE;
                    exec_res.out_buttons  = eb_mem[ehead_reg];
                    exec_res.out_triggers = et_mem[ehead_reg];
                    exec_res.out_sticks   = es_mem[ehead_reg];
                end
                else if (lp_reg && lv_reg > em_reg)
                begin
                    exec_res.item_valid   = 1'b1;
                    exec_res.item_kind    = lk_reg;
                    exec_res.out_buttons  = lb_reg;
                    exec_res.out_triggers = lt_reg;
                    exec_res.out_sticks   = ls_reg;
                end
            end
            MODE_ATTACH, MODE_NEUTRALIZE, MODE_DETACH:
            begin
                exec_res.accepted = (ccap != '0);
            end
            default:
            begin
                exec_res.accepted = 1'b1;
            end
        endcase
    end

    // Memory writes.
    logic ctrl_we;
    logic [1:0] ctrl_wkind;
    logic edge_we;
    logic [EW-1:0] edge_waddr;

    always_comb
    begin
        ctrl_we    = 1'b0;
        ctrl_wkind = KIND_ATTACH;
        edge_we    = 1'b0;
        edge_waddr = etail;
        if (cmd.exec)
        begin
            case (req_reg.mode)
                MODE_ATTACH:
                begin
                    ctrl_we = (ccap != '0);
                    ctrl_wkind = KIND_ATTACH;
                end
                MODE_NEUTRALIZE:
                begin
                    ctrl_we = (ccap != '0);
                    ctrl_wkind = KIND_NEUTRAL;
                end
                MODE_DETACH:
                begin
                    ctrl_we = (ccap != '0);
                    ctrl_wkind = KIND_DETACH;
                end
                MODE_SUBMIT:
                begin
                    if (lp_reg && lb_reg != req_reg.pad_buttons && ecap != '0)
                    begin
                        if (efill_reg >= ecap)
                        begin
                            // Oldest popped first, then appended at the old tail.
                            edge_waddr = etail;
                            edge_we = (efill_reg <= EDGE_FULL);
                        end
                        else
                        begin
                            edge_we = (efill_reg < EDGE_FULL);
                        end
                    end
                end
                default:
                begin
                    ctrl_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_we)
        begin
            // Queues are cleared by these modes, so the write goes to the head.
            ck_mem[chead_reg] <= ctrl_wkind;
            if (req_reg.mode == MODE_ATTACH)
            begin
                cb_mem[chead_reg] <= req_reg.pad_buttons;
                ct_mem[chead_reg] <= req_reg.trigger_word;
                cs_mem[chead_reg] <= req_reg.stick_word;
            end
            else
            begin
                cb_mem[chead_reg] <= '0;
                ct_mem[chead_reg] <= '0;
                cs_mem[chead_reg] <= '0;
            end
            cv_mem[chead_reg] <= vc_reg;
        end
        if (edge_we)
        begin
            eb_mem[edge_waddr]  <= req_reg.pad_buttons;
            et_mem[edge_waddr]  <= req_reg.trigger_word;
            es_mem[edge_waddr]  <= req_reg.stick_word;
            ev_mem[edge_waddr]  <= vc_reg;
            etm_mem[edge_waddr] <= req_reg.now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_limit_reg <= 3'd4;
            edge_limit_reg    <= 5'd16;
            edge_lifetime_reg <= 32'd1000;
            chead_reg    <= '0;
            cfill_reg    <= '0;
            ehead_reg    <= '0;
            efill_reg    <= '0;
            lp_reg       <= 1'b0;
            lk_reg       <= '0;
            lb_reg       <= '0;
            lt_reg       <= '0;
            ls_reg       <= '0;
            lv_reg       <= '0;
            vc_reg       <= '0;
            em_reg       <= '0;
            drop_reg     <= '0;
            hrefresh_reg <= 1'b0;
            res_reg      <= '0;
        end
        else
        begin
            hrefresh_reg <= hrefresh_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_CONTROL_LIMIT: control_limit_reg <= cfg_data[2:0];
                    CFG_EDGE_LIMIT:    edge_limit_reg    <= cfg_data[4:0];
                    CFG_EDGE_LIFETIME: edge_lifetime_reg <= cfg_data;
                    default:           control_limit_reg <= control_limit_reg;
                endcase
            end
            if (cmd.purge_pop)
            begin
                ehead_reg    <= einc(ehead_reg, EFW'(1));
                efill_reg    <= efill_reg - EFW'(1);
            end
            if (cmd.exec)
            begin
                res_reg <= exec_res;
                case (req_reg.mode)
                    MODE_SUBMIT:
                    begin
                        vc_reg <= vc_reg + 64'd1;
                        lp_reg <= 1'b1;
                        lk_reg <= KIND_STATE;
                        lb_reg <= req_reg.pad_buttons;
                        lt_reg <= req_reg.trigger_word;
                        ls_reg <= req_reg.stick_word;
                        lv_reg <= vc_reg;
                        if (lp_reg && lb_reg != req_reg.pad_buttons)
                        begin
                            if (ecap == '0)
                            begin
                                if (drop_reg != '1)
                                begin
                                    drop_reg <= drop_reg + 32'd1;
                                end
                            end
                            else if (efill_reg >= ecap)
                            begin
                                if (drop_reg != '1)
                                begin
                                    drop_reg <= drop_reg + 32'd1;
                                end
                                // Pop one then push one: fill unchanged.
                                ehead_reg    <= einc(ehead_reg, EFW'(1));
                            end
                            else
                            begin
                                efill_reg <= efill_reg + EFW'(1);
                            end
                        end
                    end
                    MODE_TAKE:
                    begin
                        if (cfill_reg != '0)
                        begin
                            if ((ck_mem[chead_reg] == KIND_STATE ||
                                 ck_mem[chead_reg] == KIND_NEUTRAL) &&
                                ctrl_ver_head > em_reg)
                            begin
                                em_reg <= ctrl_ver_head;
                            end
                            chead_reg <= cinc(chead_reg, CFW'(1));
                            cfill_reg <= cfill_reg - CFW'(1);
                        end
                        else if (efill_reg != '0)
                        begin
                            if (edge_ver_head > em_reg)
                            begin
                                em_reg <= edge_ver_head;
                            end
                            ehead_reg    <= einc(ehead_reg, EFW'(1));
                            efill_reg    <= efill_reg - EFW'(1);
                        end
                        else if (lp_reg && lv_reg > em_reg)
                        begin
                            em_reg <= lv_reg;
                        end
                    end
                    MODE_ATTACH:
                    begin
                        cfill_reg <= (ccap != '0) ? CFW'(1) : '0;
                        efill_reg <= '0;
                        em_reg    <= '0;
                        if (ccap == '0)
                        begin
                            lp_reg <= 1'b0;
                        end
                        else
                        begin
                            vc_reg <= vc_reg + 64'd2;
                            lp_reg <= 1'b1;
                            lk_reg <= KIND_STATE;
                            lb_reg <= req_reg.pad_buttons;
                            lt_reg <= req_reg.trigger_word;
                            ls_reg <= req_reg.stick_word;
                            lv_reg <= vc_reg + 64'd1;
                        end
                    end
                    MODE_NEUTRALIZE:
                    begin
                        cfill_reg <= (ccap != '0) ? CFW'(1) : '0;
                        efill_reg <= '0;
                        lk_reg <= KIND_NEUTRAL;
                        lb_reg <= '0;
                        lt_reg <= '0;
                        ls_reg <= '0;
                        lv_reg <= vc_reg;
                        if (ccap == '0)
                        begin
                            lp_reg <= 1'b0;
                        end
                        else
                        begin
                            lp_reg <= 1'b1;
                            vc_reg <= vc_reg + 64'd1;
                        end
                    end
                    MODE_DETACH:
                    begin
                        cfill_reg <= (ccap != '0) ? CFW'(1) : '0;
                        efill_reg <= '0;
                        lp_reg    <= 1'b0;
                        if (ccap != '0)
                        begin
                            vc_reg <= vc_reg + 64'd1;
                        end
                    end
                    MODE_RECONNECT:
                    begin
                        cfill_reg <= '0;
                        efill_reg <= '0;
                        if (lp_reg)
                        begin
                            lk_reg <= KIND_STATE;
                            lv_reg <= vc_reg;
                            vc_reg <= vc_reg + 64'd1;
                        end
                    end
                    default:
                    begin
                        vc_reg <= vc_reg;
                    end
                endcase
            end
            if (cmd.shift)
            begin
                res_reg.drop_total    <= drop_reg;
                res_reg.edges_waiting <= 5'(efill_reg);
            end
            else if (!cmd.exec && !cmd.purge_pop)
            begin
                res_reg.drop_total    <= drop_reg;
                res_reg.edges_waiting <= 5'(efill_reg);
            end
        end
    end

endmodule

// ----- design/input_state_edge_priority_queue_core.sv -----
// Sequence: a result is offered after its request passes the purge, execution and
// shift states; each expired edge purged adds a pop and a head stamp reload, and a
// request that moves the edge FIFO's head or writes its first entry adds one reload.
// One request at a time, taken only once the last result is accepted; the expiry purge
// is sequential: each pop is followed by a reload over the edge FIFO's read port.
// Reset: asynchronous active low; queues empty, counters zero, limits 4, 16 and 1000.
module input_state_edge_priority_queue_core
    import isepq_pkg::*;
#(
    parameter int CTRL_DEPTH = 4,
    parameter int EDGE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_req_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_req_t    out_data,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // The controller sequences each request: capture, purge of expired edges,
    // execution, a settling step for the head stamp, then the result.
    cmd_t    cmd;
    status_t status;

    isepq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds both FIFOs, the latest state and the counters.
    isepq_dp #(
        .CTRL_DEPTH (CTRL_DEPTH),
        .EDGE_DEPTH (EDGE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_req    (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_req   (out_data)
    );

    // A request is never taken while a result is being offered.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request accepted while result pending");

    // A take always succeeds, so an offered item never comes with a failed push.
    a_item_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.item_valid) |-> out_data.accepted)
        else $error("item offered with a failed control push");

    // A result is not offered while its request passes the purge, execution and shift states.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !out_valid [*3])
        else $error("result too early");

endmodule
